// ----- rtl/lcdns_pkg.sv -----
// Shared types, constants and step tables for the character-LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdns_pkg;

    // Request modes
    localparam logic [2:0] MODE_CMD    = 3'd0;
    localparam logic [2:0] MODE_DATA   = 3'd1;
    localparam logic [2:0] MODE_GOTO   = 3'd2;
    localparam logic [2:0] MODE_NUMBER = 3'd3;
    localparam logic [2:0] MODE_INIT   = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_LINE_LENGTH  = 3'd0;
    localparam logic [2:0] REG_ENABLE_HIGH  = 3'd1;
    localparam logic [2:0] REG_ENABLE_LOW   = 3'd2;
    localparam logic [2:0] REG_POWER_UP     = 3'd3;
    localparam logic [2:0] REG_INIT_SETTLE  = 3'd4;
    localparam logic [2:0] REG_CLEAR_WAIT   = 3'd5;

    // Display commands and characters
    localparam logic [7:0] CMD_DDRAM_ROW0   = 8'h80;
    localparam logic [7:0] CMD_DDRAM_ROW1   = 8'hC0;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_WAKE         = 8'h30;
    localparam logic [7:0] CMD_FOUR_BIT     = 8'h20;
    localparam logic [3:0] DIGIT_HIGH_NIB   = 4'h3;   // high nibble of '0'..'9'
    localparam logic [3:0] NIB_MASK         = 4'hF;

    // Decimal conversion
    localparam int MAX_DIGITS  = 5;
    localparam int NUMBER_W    = 16;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CONV_CNT_W  = $clog2(NUMBER_W);

    // Step queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Last step indexes of the fixed sequences
    localparam logic [3:0] INIT_LAST_STEP  = 4'd9;
    localparam logic [3:0] CLEAR_LAST_STEP = 4'd2;

    typedef enum logic [1:0] {
        WAIT_POWER_UP = 2'd0,
        WAIT_SETTLE   = 2'd1,
        WAIT_CLEAR    = 2'd2
    } wait_sel_t;

    // One queued step: a nibble write (three events) or a pure wait (one event)
    typedef struct packed {
        logic      is_wait;
        logic [3:0] nib;
        logic      rs;
        wait_sel_t wsel;
        logic      last;
    } step_t;

    typedef struct packed {
        logic [5:0]  line_length;
        logic [15:0] enable_high_wait;
        logic [15:0] enable_low_wait;
        logic [15:0] power_up_wait;
        logic [15:0] init_settle_wait;
        logic [15:0] clear_wait;
    } cfg_t;

    function automatic step_t nib_step(input logic [3:0] nib, input logic rs);
        step_t s;
        s.is_wait = 1'b0;
        s.nib     = nib;
        s.rs      = rs;
        s.wsel    = WAIT_POWER_UP;
        s.last    = 1'b0;
        return s;
    endfunction

    function automatic step_t wait_step(input wait_sel_t sel);
        step_t s;
        s.is_wait = 1'b1;
        s.nib     = 4'h0;
        s.rs      = 1'b0;
        s.wsel    = sel;
        s.last    = 1'b0;
        return s;
    endfunction

    // Power-up sequence: wait, three wake nibbles, four-bit nibble, settle, two commands
    function automatic step_t init_step(input logic [3:0] idx);
        step_t s;
        case (idx)
            4'd0:    s = wait_step(WAIT_POWER_UP);
            4'd1:    s = nib_step(CMD_WAKE[7:4], 1'b0);
            4'd2:    s = nib_step(CMD_WAKE[7:4], 1'b0);
            4'd3:    s = nib_step(CMD_WAKE[7:4], 1'b0);
            4'd4:    s = nib_step(CMD_FOUR_BIT[7:4], 1'b0);
            4'd5:    s = wait_step(WAIT_SETTLE);
            4'd6:    s = nib_step(CMD_FUNCTION_SET[7:4], 1'b0);
            4'd7:    s = nib_step(CMD_FUNCTION_SET[3:0], 1'b0);
            4'd8:    s = nib_step(CMD_DISPLAY_ON[7:4], 1'b0);
            4'd9:    s = nib_step(CMD_DISPLAY_ON[3:0], 1'b0);
            default: s = nib_step(4'h0, 1'b0);
        endcase
        return s;
    endfunction

    // Clear sequence: clear command, then the long wait
    function automatic step_t clear_step(input logic [3:0] idx);
        step_t s;
        case (idx)
            4'd0:    s = nib_step(CMD_CLEAR[7:4], 1'b0);
            4'd1:    s = nib_step(CMD_CLEAR[3:0], 1'b0);
            default: s = wait_step(WAIT_CLEAR);
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/lcdns_front.sv -----
// Front end: accepts requests, converts numbers to decimal and issues nibble/wait steps.
`timescale 1ns / 1ps

module lcdns_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [7:0]            byte_value,
    input  logic [5:0]            column,
    input  logic [2:0]            row,
    input  logic [15:0]           number_value,
    input  logic [5:0]            line_length,
    input  logic                  q_full,
    output logic                  q_push,
    output lcdns_pkg::step_t      q_step
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CONV  = 3'b010,
        ST_ISSUE = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_NUM   = 2'd1,
        KIND_INIT  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    state_t                            state_reg, state_next;
    kind_t                             kind_reg, kind_next;
    logic [7:0]                        byte_reg, byte_next;
    logic                              rs_reg, rs_next;
    logic [3:0]                        step_reg, step_next;
    logic [lcdns_pkg::DIGIT_IDX_W-1:0] digit_idx_reg, digit_idx_next;
    logic                              started_reg, started_next;
    logic [lcdns_pkg::NUMBER_W-1:0]    bin_reg, bin_next;
    logic [lcdns_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [lcdns_pkg::CONV_CNT_W-1:0]  cnt_reg, cnt_next;

    logic [7:0]                  goto_byte;
    logic [lcdns_pkg::BCD_W-1:0] bcd_adj;
    logic [3:0]                  digit;
    lcdns_pkg::step_t            step;
    logic                        skip;
    logic                        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Cursor address with the line offset for the lower display rows
    assign goto_byte = (row[0] ? lcdns_pkg::CMD_DDRAM_ROW1 : lcdns_pkg::CMD_DDRAM_ROW0)
                     + {2'b00, column}
                     + (row[1] ? {2'b00, line_length} : 8'h00);

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < lcdns_pkg::MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    assign digit = bcd_reg[{digit_idx_reg, 2'b00} +: 4];

    // Build the current step
    always_comb
    begin
        step = lcdns_pkg::nib_step(4'h0, 1'b0);
        skip = 1'b0;
        case (kind_reg)
            KIND_BYTE:
            begin
                step      = lcdns_pkg::nib_step(step_reg[0] ? byte_reg[3:0] : byte_reg[7:4],
                                                rs_reg);
                step.last = step_reg[0];
            end
            KIND_NUM:
            begin
                step      = lcdns_pkg::nib_step(step_reg[0] ? digit
                                                            : lcdns_pkg::DIGIT_HIGH_NIB, 1'b1);
                step.last = step_reg[0] && (digit_idx_reg == '0);
                skip      = !started_reg && !step_reg[0] && (digit == 4'h0)
                         && (digit_idx_reg != '0);
            end
            KIND_INIT:
            begin
                step      = lcdns_pkg::init_step(step_reg);
                step.last = (step_reg == lcdns_pkg::INIT_LAST_STEP);
            end
            KIND_CLEAR:
            begin
                step      = lcdns_pkg::clear_step(step_reg);
                step.last = (step_reg == lcdns_pkg::CLEAR_LAST_STEP);
            end
            default:
            begin
                step = lcdns_pkg::nib_step(4'h0, 1'b0);
            end
        endcase
    end

    assign q_step = step;
    assign q_push = (state_reg == ST_ISSUE) && !skip && !q_full;

    // Sequence control
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        step_next      = step_reg;
        digit_idx_next = digit_idx_reg;
        started_next   = started_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next      = 4'd0;
                digit_idx_next = lcdns_pkg::DIGIT_IDX_W'(lcdns_pkg::MAX_DIGITS - 1);
                started_next   = 1'b0;
                if (accept)
                begin
                    case (mode)
                        lcdns_pkg::MODE_CMD:
                        begin
                            kind_next  = KIND_BYTE;
                            byte_next  = byte_value;
                            rs_next    = 1'b0;
                            state_next = ST_ISSUE;
                        end
                        lcdns_pkg::MODE_DATA:
                        begin
                            kind_next  = KIND_BYTE;
                            byte_next  = byte_value;
                            rs_next    = 1'b1;
                            state_next = ST_ISSUE;
                        end
                        lcdns_pkg::MODE_GOTO:
                        begin
                            kind_next = KIND_BYTE;
                            byte_next = goto_byte;
                            rs_next   = 1'b0;
                            // drop rows beyond the fourth
                            if (!row[2])
                            begin
                                state_next = ST_ISSUE;
                            end
                        end
                        lcdns_pkg::MODE_NUMBER:
                        begin
                            kind_next  = KIND_NUM;
                            bin_next   = number_value;
                            bcd_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CONV;
                        end
                        lcdns_pkg::MODE_INIT:
                        begin
                            kind_next  = KIND_INIT;
                            state_next = ST_ISSUE;
                        end
                        lcdns_pkg::MODE_CLEAR:
                        begin
                            kind_next  = KIND_CLEAR;
                            state_next = ST_ISSUE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // shift one binary bit into the BCD register per cycle
                bcd_next = {bcd_adj[lcdns_pkg::BCD_W-2:0], bin_reg[lcdns_pkg::NUMBER_W-1]};
                bin_next = {bin_reg[lcdns_pkg::NUMBER_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lcdns_pkg::CONV_CNT_W'(lcdns_pkg::NUMBER_W - 1))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (skip)
                begin
                    digit_idx_next = digit_idx_reg - 1'b1;
                end
                else if (q_push)
                begin
                    if (step.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (kind_reg == KIND_NUM)
                    begin
                        started_next = 1'b1;
                        if (step_reg[0])
                        begin
                            step_next      = 4'd0;
                            digit_idx_next = digit_idx_reg - 1'b1;
                        end
                        else
                        begin
                            step_next = 4'd1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            digit_idx_reg <= '0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            kind_reg      <= KIND_BYTE;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            digit_idx_reg <= digit_idx_next;
            started_reg   <= started_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
        end
    end

    // Hold request payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
    end

endmodule

// ----- rtl/lcdns_queue.sv -----
// Short step queue between the front end and the event generator.
`timescale 1ns / 1ps

module lcdns_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdns_pkg::step_t push_step,
    input  logic             pop,
    output lcdns_pkg::step_t pop_step,
    output logic             empty,
    output logic             full
);

    lcdns_pkg::step_t                mem_reg [lcdns_pkg::QUEUE_DEPTH];
    logic [lcdns_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lcdns_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lcdns_pkg::QPTR_W:0]      count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (lcdns_pkg::QPTR_W + 1)'(lcdns_pkg::QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_step = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_step;
        end
    end

endmodule

// ----- rtl/lcdns_back.sv -----
// Back end: expands queued steps into timed pin events behind an output register.
`timescale 1ns / 1ps

module lcdns_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  lcdns_pkg::cfg_t  cfg,
    input  logic             q_empty,
    input  lcdns_pkg::step_t q_step,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [3:0]       pin_data,
    output logic             pin_rs,
    output logic             pin_e,
    output logic [15:0]      wait_us,
    output logic             last
);

    localparam logic [1:0] PH_E_HIGH = 2'd0;
    localparam logic [1:0] PH_E_LOW  = 2'd1;

    logic             cur_valid_reg, cur_valid_next;
    lcdns_pkg::step_t cur_reg, cur_next;
    logic [1:0]       phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       data_reg;
    logic             rs_reg;
    logic             e_reg;
    logic [15:0]      wait_reg;
    logic             last_reg;

    logic [3:0]  ev_data;
    logic        ev_rs;
    logic        ev_e;
    logic [15:0] ev_wait;
    logic        ev_final;
    logic        out_load;

    // Form the event for the current step and phase
    always_comb
    begin
        ev_data  = 4'h0;
        ev_rs    = 1'b0;
        ev_e     = 1'b0;
        ev_wait  = 16'h0000;
        ev_final = 1'b1;
        if (cur_reg.is_wait)
        begin
            case (cur_reg.wsel)
                lcdns_pkg::WAIT_POWER_UP: ev_wait = cfg.power_up_wait;
                lcdns_pkg::WAIT_SETTLE:   ev_wait = cfg.init_settle_wait;
                lcdns_pkg::WAIT_CLEAR:    ev_wait = cfg.clear_wait;
                default:                  ev_wait = 16'h0000;
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_E_HIGH:
                begin
                    ev_data  = cur_reg.nib;
                    ev_rs    = cur_reg.rs;
                    ev_e     = 1'b1;
                    ev_wait  = cfg.enable_high_wait;
                    ev_final = 1'b0;
                end
                PH_E_LOW:
                begin
                    ev_data  = cur_reg.nib;
                    ev_rs    = cur_reg.rs;
                    ev_wait  = cfg.enable_low_wait;
                    ev_final = 1'b0;
                end
                default:
                begin
                    ev_final = 1'b1;
                end
            endcase
        end
    end

    assign out_load = cur_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop    = !q_empty && (!cur_valid_reg || (out_load && ev_final));

    // Advance through the current step
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_step;
            phase_next     = PH_E_HIGH;
        end
        else if (out_load && ev_final)
        begin
            cur_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            phase_next = phase_reg + 2'd1;
        end
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_E_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_load)
        begin
            data_reg <= ev_data;
            rs_reg   <= ev_rs;
            e_reg    <= ev_e;
            wait_reg <= ev_wait;
            last_reg <= ev_final && cur_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_data  = data_reg;
    assign pin_rs    = rs_reg;
    assign pin_e     = e_reg;
    assign wait_us   = wait_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the character-LCD nibble sequencer: registers, front end, queue, back end.
`timescale 1ns / 1ps

// Each request becomes a list of timed pin events for a 4-bit HD44780-style display:
// commands, data bytes and cursor moves give 6 events, init gives 26, clear gives 7, a
// number gives 6 per printed digit, and a goto to a row above three or an unknown mode
// gives none. Events leave at one per clock while out_ready is high and steps are queued;
// the back end that expands each nibble into its three events sets that pace. A number
// request first passes through the binary-to-BCD converter and then drops up to four
// leading zeros. The front end takes one request at a time and is ready again once the
// last step of the current request is queued, so it runs ahead of the back end by the
// four queue entries. Configuration writes are always taken (cfg_ready is tied high);
// indexes beyond five are ignored.

module char_lcd_nibble_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [5:0]  column,
    input  logic [2:0]  row,
    input  logic [15:0] number_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  pin_data,
    output logic        pin_rs,
    output logic        pin_e,
    output logic [15:0] wait_us,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lcdns_pkg::cfg_t  cfg_reg, cfg_next;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    lcdns_pkg::step_t q_push_step;
    lcdns_pkg::step_t q_pop_step;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcdns_pkg::REG_LINE_LENGTH: cfg_next.line_length      = cfg_data[5:0];
                lcdns_pkg::REG_ENABLE_HIGH: cfg_next.enable_high_wait = cfg_data;
                lcdns_pkg::REG_ENABLE_LOW:  cfg_next.enable_low_wait  = cfg_data;
                lcdns_pkg::REG_POWER_UP:    cfg_next.power_up_wait    = cfg_data;
                lcdns_pkg::REG_INIT_SETTLE: cfg_next.init_settle_wait = cfg_data;
                lcdns_pkg::REG_CLEAR_WAIT:  cfg_next.clear_wait       = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_length      <= 6'd20;
            cfg_reg.enable_high_wait <= 16'd700;
            cfg_reg.enable_low_wait  <= 16'd400;
            cfg_reg.power_up_wait    <= 16'd50000;
            cfg_reg.init_settle_wait <= 16'd10000;
            cfg_reg.clear_wait       <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcdns_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .byte_value   (byte_value),
        .column       (column),
        .row          (row),
        .number_value (number_value),
        .line_length  (cfg_reg.line_length),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_step       (q_push_step)
    );

    lcdns_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_step (q_push_step),
        .pop       (q_pop),
        .pop_step  (q_pop_step),
        .empty     (q_empty),
        .full      (q_full)
    );

    lcdns_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_step    (q_pop_step),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pin_data  (pin_data),
        .pin_rs    (pin_rs),
        .pin_e     (pin_e),
        .wait_us   (wait_us),
        .last      (last)
    );

    // An enable-high event never closes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pin_e) |-> !last)
        else $error("enable-high event marked last");

    // A taken enable-high event is followed at once by its enable-low event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && pin_e) |=>
            (out_valid && !pin_e && pin_data == $past(pin_data) && pin_rs == $past(pin_rs)))
        else $error("enable-low event missing after enable-high");

    // The front end never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full step queue");

endmodule

// ----- verif/tb_char_lcd_nibble_sequencer.sv -----
// Self-checking testbench for the character-LCD nibble sequencer.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 40;      // covers BCD conversion plus queue drain

    // Mode and register codes the block does not decode
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [3:0]  data;
        logic        rs;
        logic        e;
        logic [15:0] wait_us;
        logic        last;
    } pin_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [7:0]  byte_value = '0;
    logic [5:0]  column = '0;
    logic [2:0]  row = '0;
    logic [15:0] number_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  pin_data;
    logic        pin_rs;
    logic        pin_e;
    logic [15:0] wait_us;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pin_event_t          expected_pins[$];
    lcdns_pkg::cfg_t     shadow_cfg;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int hold_serial = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int events_checked = 0;
    int requests_accepted = 0;
    int registers_written = 0;
    int last_request_events = 0;
    int cycles_run = 0;

    char_lcd_nibble_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .byte_value   (byte_value),
        .column       (column),
        .row          (row),
        .number_value (number_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pin_data     (pin_data),
        .pin_rs       (pin_rs),
        .pin_e        (pin_e),
        .wait_us      (wait_us),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predict pin events ---------------------------------------------------

    function automatic void queue_pin_event(input logic [3:0] d, input logic rs,
                                            input logic e, input logic [15:0] w);
        pin_event_t ev;
        ev.data    = d;
        ev.rs      = rs;
        ev.e       = e;
        ev.wait_us = w;
        ev.last    = 1'b0;
        expected_pins.push_back(ev);
    endfunction

    function automatic void queue_nibble(input logic [3:0] nib, input logic rs);
        queue_pin_event(nib, rs, 1'b1, shadow_cfg.enable_high_wait);
        queue_pin_event(nib, rs, 1'b0, shadow_cfg.enable_low_wait);
        queue_pin_event(4'h0, 1'b0, 1'b0, 16'd0);
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic rs);
        queue_nibble(b[7:4], rs);
        queue_nibble(b[3:0], rs);
    endfunction

    function automatic void queue_decimal(input logic [15:0] value);
        logic [3:0] digits [lcdns_pkg::MAX_DIGITS];
        int         remaining;
        int         top;
        remaining = int'(value);
        top = -1;
        for (int i = 0; i < lcdns_pkg::MAX_DIGITS; i++)
        begin
            digits[i] = 4'(remaining % 10);
            remaining = remaining / 10;
            if (digits[i] != 4'd0)
                top = i;
        end
        if (top < 0)
            queue_byte(8'd48, 1'b1);
        else
            for (int i = top; i >= 0; i--)
                queue_byte(8'd48 + {4'd0, digits[i]}, 1'b1);
    endfunction

    // Expand one request into its events; returns the number queued
    function automatic int expand_request(input logic [2:0] m, input logic [7:0] b,
                                          input logic [5:0] c, input logic [2:0] r,
                                          input logic [15:0] n);
        int         start_size;
        logic [7:0] offset;
        start_size = expected_pins.size();
        offset = {2'b00, shadow_cfg.line_length} + {2'b00, c};
        case (m)
            lcdns_pkg::MODE_CMD:    queue_byte(b, 1'b0);
            lcdns_pkg::MODE_DATA:   queue_byte(b, 1'b1);
            lcdns_pkg::MODE_GOTO:
                case (r)
                    3'd0:    queue_byte(lcdns_pkg::CMD_DDRAM_ROW0 + {2'b00, c}, 1'b0);
                    3'd1:    queue_byte(lcdns_pkg::CMD_DDRAM_ROW1 + {2'b00, c}, 1'b0);
                    3'd2:    queue_byte(lcdns_pkg::CMD_DDRAM_ROW0 + offset, 1'b0);
                    3'd3:    queue_byte(lcdns_pkg::CMD_DDRAM_ROW1 + offset, 1'b0);
                    default: ;
                endcase
            lcdns_pkg::MODE_NUMBER: queue_decimal(n);
            lcdns_pkg::MODE_INIT:
            begin
                queue_pin_event(4'h0, 1'b0, 1'b0, shadow_cfg.power_up_wait);
                queue_nibble(lcdns_pkg::CMD_WAKE[7:4], 1'b0);
                queue_nibble(lcdns_pkg::CMD_WAKE[7:4], 1'b0);
                queue_nibble(lcdns_pkg::CMD_WAKE[7:4], 1'b0);
                queue_nibble(lcdns_pkg::CMD_FOUR_BIT[7:4], 1'b0);
                queue_pin_event(4'h0, 1'b0, 1'b0, shadow_cfg.init_settle_wait);
                queue_byte(lcdns_pkg::CMD_FUNCTION_SET, 1'b0);
                queue_byte(lcdns_pkg::CMD_DISPLAY_ON, 1'b0);
            end
            lcdns_pkg::MODE_CLEAR:
            begin
                queue_byte(lcdns_pkg::CMD_CLEAR, 1'b0);
                queue_pin_event(4'h0, 1'b0, 1'b0, shadow_cfg.clear_wait);
            end
            default: ;
        endcase
        if (expected_pins.size() > start_size)
            expected_pins[expected_pins.size() - 1].last = 1'b1;
        return expected_pins.size() - start_size;
    endfunction

    // Check each accepted event --------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH at event %0d, %s: got %0h, want %0h",
                 events_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_pin_events
        pin_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pins.size() == 0)
                report_mismatch("event with nothing pending", int'(pin_data), 0);
            else
            begin
                want = expected_pins.pop_front();
                if (pin_data !== want.data)
                    report_mismatch("pin_data", int'(pin_data), int'(want.data));
                if (pin_rs !== want.rs)
                    report_mismatch("pin_rs", int'(pin_rs), int'(want.rs));
                if (pin_e !== want.e)
                    report_mismatch("pin_e", int'(pin_e), int'(want.e));
                if (wait_us !== want.wait_us)
                    report_mismatch("wait_us", int'(wait_us), int'(want.wait_us));
                if (last !== want.last)
                    report_mismatch("last", int'(last), int'(want.last));
            end
            events_checked++;
        end
    end

    // Drive output ready; a requested hold-off overrides the random stalls
    always @(posedge clk)
    begin
        if (hold_taken != hold_serial)
        begin
            hold_taken = hold_serial;
            hold_left  = hold_len;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Give up on a hung run
    initial
    begin : watchdog
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("char_lcd_nibble_sequencer regression: fail");
        $finish;
    end

    // Stimulus helpers -----------------------------------------------------

    task automatic send_request(input logic [2:0] req_mode, input logic [7:0] req_byte,
                                input logic [5:0] req_col, input logic [2:0] req_row,
                                input logic [15:0] req_num);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        mode         <= req_mode;
        byte_value   <= req_byte;
        column       <= req_col;
        row          <= req_row;
        number_value <= req_num;
        do
            @(posedge clk);
        while (!in_ready);
        last_request_events = expand_request(req_mode, req_byte, req_col, req_row, req_num);
        requests_accepted++;
    endtask

    // Hold the output off for a number of cycles
    task automatic hold_receiver(input int cycles);
        hold_len = cycles;
        hold_serial++;
    endtask

    // Drop valid, wait for every pending event, then let the pipeline settle
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lcdns_pkg::REG_LINE_LENGTH: shadow_cfg.line_length      = value[5:0];
            lcdns_pkg::REG_ENABLE_HIGH: shadow_cfg.enable_high_wait = value;
            lcdns_pkg::REG_ENABLE_LOW:  shadow_cfg.enable_low_wait  = value;
            lcdns_pkg::REG_POWER_UP:    shadow_cfg.power_up_wait    = value;
            lcdns_pkg::REG_INIT_SETTLE: shadow_cfg.init_settle_wait = value;
            lcdns_pkg::REG_CLEAR_WAIT:  shadow_cfg.clear_wait       = value;
            default: ;
        endcase
        registers_written++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a register value: low extreme, high extreme or anything
    function automatic logic [15:0] pick_register_value();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_registers();
        write_register(lcdns_pkg::REG_LINE_LENGTH, pick_register_value());
        write_register(lcdns_pkg::REG_ENABLE_HIGH, pick_register_value());
        write_register(lcdns_pkg::REG_ENABLE_LOW,  pick_register_value());
        write_register(lcdns_pkg::REG_POWER_UP,    pick_register_value());
        write_register(lcdns_pkg::REG_INIT_SETTLE, pick_register_value());
        write_register(lcdns_pkg::REG_CLEAR_WAIT,  pick_register_value());
        write_register($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, 16'($urandom));
    endtask

    task automatic send_random_request();
        logic [2:0]  m;
        logic [2:0]  r;
        logic [15:0] n;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 18)      m = lcdns_pkg::MODE_CMD;
        else if (pick < 40) m = lcdns_pkg::MODE_DATA;
        else if (pick < 60) m = lcdns_pkg::MODE_GOTO;
        else if (pick < 80) m = lcdns_pkg::MODE_NUMBER;
        else if (pick < 86) m = lcdns_pkg::MODE_INIT;
        else if (pick < 94) m = lcdns_pkg::MODE_CLEAR;
        else                m = $urandom_range(1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
        r = ($urandom_range(99) < 85) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
        // Spread number widths so every digit count shows up
        case ($urandom_range(4))
            0:       n = 16'($urandom_range(9));
            1:       n = 16'($urandom_range(99));
            2:       n = 16'($urandom_range(999));
            3:       n = 16'($urandom_range(9999));
            default: n = 16'($urandom);
        endcase
        send_request(m, 8'($urandom), 6'($urandom), r, n);
    endtask

    // Tests ----------------------------------------------------------------

    // Every mode and field extreme at the reset register values
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(lcdns_pkg::MODE_CMD,    8'h00, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_CMD,    8'hFF, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_DATA,   8'h00, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_DATA,   8'hFF, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_DATA,   8'hA5, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd63, 3'd1, 16'd0);
        send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd5,  3'd2, 16'd0);
        send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd63, 3'd3, 16'd0);  // address wraps
        send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd10, 3'd4, 16'd0);  // no such row
        send_request(lcdns_pkg::MODE_GOTO,   8'hFF, 6'd63, 3'd7, 16'hFFFF);
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd0);  // zero prints '0'
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd7);
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd10);
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd100);
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd10000);
        send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd65535);
        send_request(lcdns_pkg::MODE_INIT,   8'h00, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_CLEAR,  8'h00, 6'd0,  3'd0, 16'd0);
        send_request(MODE_UNUSED_LO, 8'hFF, 6'd63, 3'd7, 16'hFFFF);
        send_request(MODE_UNUSED_HI, 8'h00, 6'd0,  3'd0, 16'd0);
        send_request(lcdns_pkg::MODE_CMD,    8'h5A, 6'd0,  3'd0, 16'd0);
        wait_for_drain();
    endtask

    // All registers at their low extremes, then at their high extremes
    task automatic test_register_extremes();
        for (int pass = 0; pass < 2; pass++)
        begin
            // upper bits of the line length are masked off
            write_register(lcdns_pkg::REG_LINE_LENGTH, pass ? 16'hFFFF : 16'hFFC0);
            write_register(lcdns_pkg::REG_ENABLE_HIGH, pass ? 16'hFFFF : 16'h0000);
            write_register(lcdns_pkg::REG_ENABLE_LOW,  pass ? 16'hFFFF : 16'h0000);
            write_register(lcdns_pkg::REG_POWER_UP,    pass ? 16'hFFFF : 16'h0000);
            write_register(lcdns_pkg::REG_INIT_SETTLE, pass ? 16'hFFFF : 16'h0000);
            write_register(lcdns_pkg::REG_CLEAR_WAIT,  pass ? 16'hFFFF : 16'h0000);
            write_register(REG_UNMAPPED_LO, 16'h1234);
            write_register(REG_UNMAPPED_HI, 16'hFFFF);
            send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd63, 3'd3, 16'd0);
            send_request(lcdns_pkg::MODE_GOTO,   8'h00, 6'd63, 3'd2, 16'd0);
            send_request(lcdns_pkg::MODE_INIT,   8'h00, 6'd0,  3'd0, 16'd0);
            send_request(lcdns_pkg::MODE_CLEAR,  8'h00, 6'd0,  3'd0, 16'd0);
            send_request(lcdns_pkg::MODE_CMD,    8'hFF, 6'd0,  3'd0, 16'd0);
            send_request(lcdns_pkg::MODE_NUMBER, 8'h00, 6'd0,  3'd0, 16'd65535);
            wait_for_drain();
        end
    endtask

    // Long output stall while requests keep coming, then a pause and a restart
    task automatic test_fill_and_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_receiver(400);
        repeat (12) send_random_request();
        wait_for_drain();
        hold_receiver(150);
        repeat (8) send_random_request();
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                       input int useful_requests);
        int useful;
        useful = 0;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        while (useful < useful_requests)
        begin
            send_random_request();
            if (last_request_events > 0)
                useful++;
            // Change settings part way through, with the block idle
            if (useful == useful_requests / 2 && last_request_events > 0)
            begin
                wait_for_drain();
                randomize_registers();
            end
        end
        wait_for_drain();
    endtask

    initial
    begin
        shadow_cfg.line_length      = 6'd20;
        shadow_cfg.enable_high_wait = 16'd700;
        shadow_cfg.enable_low_wait  = 16'd400;
        shadow_cfg.power_up_wait    = 16'd50000;
        shadow_cfg.init_settle_wait = 16'd10000;
        shadow_cfg.clear_wait       = 16'd1000;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_fill_and_stall();
        randomize_registers();
        test_random_traffic(9, 51, 86);
        randomize_registers();
        test_random_traffic(51, 9, 86);
        randomize_registers();
        test_random_traffic(0, 0, 86);

        $display("Covered %0d requests and %0d pin events over %0d register writes,",
                 requests_accepted, events_checked, registers_written);
        $display("with register extremes, a long output stall and three idle mixes.");
        if (mismatch_count == 0 && expected_pins.size() == 0)
            $display("char_lcd_nibble_sequencer regression: pass");
        else
            $display("char_lcd_nibble_sequencer regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lcdns_pkg.sv
rtl/lcdns_front.sv
rtl/lcdns_queue.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer.sv
verif/tb_char_lcd_nibble_sequencer.sv
